>>> rtl/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types, constants and the microcode program of the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int SKF_SAMPLE_WIDTH = 16;
    localparam int SKF_FRAC_BITS    = 16;

    localparam logic [31:0] Q_RESET = 32'd66;
    localparam logic [31:0] R_RESET = 32'd35586;

    localparam int STEP_W = 3;

    localparam logic [STEP_W-1:0] STEP_LOAD   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_DIV    = 3'd1;
    localparam logic [STEP_W-1:0] STEP_CINIT  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_CMUL   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_UPD    = 3'd4;
    localparam logic [STEP_W-1:0] STEP_PMUL   = 3'd5;
    localparam logic [STEP_W-1:0] STEP_FINISH = 3'd6;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIVSTEP,
        OP_CINIT,
        OP_MULSTEP,
        OP_UPD,
        OP_FINISH
    } t_op;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_WAIT_IN,
        COND_LOOP,
        COND_WAIT_OUT
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] nxt;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic go;
    } t_ctrl;

    typedef struct packed {
        logic cnt_zero;
        logic out_free;
    } t_stat;

    function automatic t_uword ucode_rom(input logic [STEP_W-1:0] pc);
        t_uword w;
        unique case (pc)
            STEP_LOAD:   w = '{op: OP_LOAD,    cond: COND_WAIT_IN,  nxt: STEP_DIV};
            STEP_DIV:    w = '{op: OP_DIVSTEP, cond: COND_LOOP,     nxt: STEP_CINIT};
            STEP_CINIT:  w = '{op: OP_CINIT,   cond: COND_NONE,     nxt: STEP_CMUL};
            STEP_CMUL:   w = '{op: OP_MULSTEP, cond: COND_LOOP,     nxt: STEP_UPD};
            STEP_UPD:    w = '{op: OP_UPD,     cond: COND_NONE,     nxt: STEP_PMUL};
            STEP_PMUL:   w = '{op: OP_MULSTEP, cond: COND_LOOP,     nxt: STEP_FINISH};
            STEP_FINISH: w = '{op: OP_FINISH,  cond: COND_WAIT_OUT, nxt: STEP_LOAD};
            default:     w = '{op: OP_NOP,     cond: COND_NONE,     nxt: STEP_LOAD};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/skf_seq.sv
// ----------------------------------------------------------------------------
// skf_seq
// Step counter and microcode table; resolves conditional jumps.
// ----------------------------------------------------------------------------
module skf_seq
    import skf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_stat i_stat,
    output t_ctrl o_ctrl,
    output logic  o_stall
);

    logic [STEP_W-1:0] r_pc;
    logic [STEP_W-1:0] n_pc;
    t_uword            w_uw;
    logic              w_met;

    assign w_uw = ucode_rom(r_pc);

    always_comb begin
        unique case (w_uw.cond)
            COND_NONE:     w_met = 1'b1;
            COND_WAIT_IN:  w_met = i_valid;
            COND_LOOP:     w_met = i_stat.cnt_zero;
            COND_WAIT_OUT: w_met = i_stat.out_free;
            default:       w_met = 1'b1;
        endcase
        n_pc = w_met ? w_uw.nxt : r_pc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.op = w_uw.op;
    assign o_ctrl.go = w_met;
    assign o_stall   = (r_pc != STEP_LOAD);

endmodule

>>> rtl/skf_dp.sv
// ----------------------------------------------------------------------------
// skf_dp
// Datapath: covariance predict, restoring divider, shift-add multiplier,
// estimate/covariance state and the output word register.
// ----------------------------------------------------------------------------
module skf_dp
    import skf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SKF_SAMPLE_WIDTH,
    parameter int FRAC_BITS    = SKF_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctrl                   i_ctrl,
    input  logic [SAMPLE_WIDTH-1:0] i_measurement,
    input  logic [31:0]             i_q,
    input  logic [31:0]             i_r,
    input  logic                    i_stall,
    output t_stat                   o_stat,
    output logic                    o_valid,
    output logic [31:0]             o_estimate
);

    localparam int DW   = ((SAMPLE_WIDTH + FRAC_BITS > 33) ?
                           SAMPLE_WIDTH + FRAC_BITS : 33) + 1;
    localparam int GW   = FRAC_BITS + 1;
    localparam int PW   = DW + GW;
    localparam int CW   = PW - FRAC_BITS;
    localparam int CNTW = $clog2(FRAC_BITS + 1);

    localparam logic [GW-1:0]   ONE_FX   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [CNTW-1:0] CNT_LOAD = CNTW'(FRAC_BITS);

    logic [31:0]             r_est;
    logic [31:0]             r_cov;
    logic [31:0]             r_p;
    logic [32:0]             r_den;
    logic [33:0]             r_rem;
    logic [GW-1:0]           r_q;
    logic [SAMPLE_WIDTH-1:0] r_meas;
    logic                    r_neg;
    logic [PW-1:0]           r_mcand;
    logic [GW-1:0]           r_mult;
    logic [PW-1:0]           r_acc;
    logic [CNTW-1:0]         r_cnt;
    logic [31:0]             r_out;
    logic                    r_out_valid;

    logic [32:0]    w_psum;
    logic [31:0]    w_p;
    logic [32:0]    w_den;
    logic           w_ge;
    logic [33:0]    w_sub;
    logic [DW-1:0]  w_mfx;
    logic [DW-1:0]  w_diff;
    logic [DW-1:0]  w_mag;
    logic [GW-1:0]  w_gain;
    logic [CW-1:0]  w_corr;
    logic [CW:0]    w_sum;
    logic [31:0]    w_est;

    always_comb begin
        w_psum = {1'b0, r_cov} + {1'b0, i_q};
        w_p    = w_psum[32] ? 32'hFFFF_FFFF : w_psum[31:0];
        w_den  = {1'b0, w_p} + {1'b0, i_r};

        w_ge   = (r_rem >= {1'b0, r_den});
        w_sub  = w_ge ? (r_rem - {1'b0, r_den}) : r_rem;

        w_mfx  = {{(DW - SAMPLE_WIDTH - FRAC_BITS){r_meas[SAMPLE_WIDTH-1]}},
                  r_meas, {FRAC_BITS{1'b0}}};
        w_diff = w_mfx - DW'(r_est);
        w_mag  = w_diff[DW-1] ? (~w_diff + DW'(1)) : w_diff;
        w_gain = (r_den == 33'd0) ? '0 : r_q;

        w_corr = r_acc[PW-1:FRAC_BITS];
        w_sum  = {1'b0, w_corr} + (CW + 1)'(r_est);
        if (r_neg) begin
            w_est = (w_corr >= CW'(r_est)) ? 32'd0 : (r_est - w_corr[31:0]);
        end else begin
            w_est = (|w_sum[CW:32]) ? 32'hFFFF_FFFF : w_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est       <= '0;
            r_cov       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.op == OP_UPD) begin
                r_est <= w_est;
            end
            if (i_ctrl.op == OP_FINISH && i_ctrl.go) begin
                r_cov       <= r_acc[FRAC_BITS+31:FRAC_BITS];
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            OP_LOAD: begin
                if (i_ctrl.go) begin
                    r_meas <= i_measurement;
                    r_p    <= w_p;
                    r_den  <= w_den;
                    r_rem  <= {2'b00, w_p};
                    r_q    <= '0;
                    r_cnt  <= CNT_LOAD;
                end
            end
            OP_DIVSTEP: begin
                r_rem <= {w_sub[32:0], 1'b0};
                r_q   <= {r_q[GW-2:0], w_ge};
                r_cnt <= r_cnt - CNTW'(1);
            end
            OP_CINIT: begin
                r_neg   <= w_diff[DW-1];
                r_mcand <= PW'(w_mag);
                r_q     <= w_gain;
                r_mult  <= w_gain;
                r_acc   <= '0;
                r_cnt   <= CNT_LOAD;
            end
            OP_MULSTEP: begin
                r_acc   <= r_acc + (r_mult[0] ? r_mcand : '0);
                r_mcand <= {r_mcand[PW-2:0], 1'b0};
                r_mult  <= {1'b0, r_mult[GW-1:1]};
                r_cnt   <= r_cnt - CNTW'(1);
            end
            OP_UPD: begin
                r_mcand <= PW'(r_p);
                r_mult  <= ONE_FX - r_q;
                r_acc   <= '0;
                r_cnt   <= CNT_LOAD;
            end
            OP_FINISH: begin
                if (i_ctrl.go) begin
                    r_out <= r_est;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stat.cnt_zero = (r_cnt == '0);
    assign o_stat.out_free = !r_out_valid || !i_stall;
    assign o_valid         = r_out_valid;
    assign o_estimate      = r_out;

endmodule

>>> rtl/scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional fixed-point Kalman filter on a signed sensor stream.
//
// Input channel: i_valid / o_stall with i_measurement, one sample per word.
// Output channel: o_valid / i_stall with o_estimate (unsigned Q16.16).
// Registers on the APB port: 0x0 process noise Q, 0x4 measurement noise R.
// Write them only while the filter is idle.
//
// From acceptance to result, each sample passes the restoring divider, one
// gain bit per cycle, then two passes of the shift-add multiplier, one
// multiplier bit per cycle. A new sample is taken once the previous one has
// finished; o_stall is high while a sample is in work. The result sits in
// an output register, so the next sample can run while it waits; a stalled
// receiver only holds the final step of the following sample.
// Reset (synchronous, i_rst_n low) clears estimate and covariance, sets Q
// and R to their defaults and empties the output register.
// ----------------------------------------------------------------------------
module scalar_kalman_filter
    import skf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SKF_SAMPLE_WIDTH,
    parameter int FRAC_BITS    = SKF_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [SAMPLE_WIDTH-1:0] i_measurement,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [31:0]             o_estimate,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [31:0] r_q;
    logic [31:0] r_r;
    t_ctrl       w_ctrl;
    t_stat       w_stat;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? r_r : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= Q_RESET;
            r_r <= R_RESET;
        end else if (w_wr) begin
            if (paddr[2]) begin
                r_r <= pwdata;
            end else begin
                r_q <= pwdata;
            end
        end
    end

    skf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_stall (o_stall)
    );

    skf_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_measurement (i_measurement),
        .i_q           (r_q),
        .i_r           (r_r),
        .i_stall       (i_stall),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .o_estimate    (o_estimate)
    );

    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall
    ) else $error("input accepted but filter not busy next cycle");

    a_valid_from_finish: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_ctrl.op == OP_FINISH && w_ctrl.go)
    ) else $error("output word appeared without a finish step");

    a_ready_only_at_load: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op != OP_LOAD) |-> o_stall
    ) else $error("input ready outside the load step");

endmodule

>>> tb/skf_tb_pkg.sv
// ----------------------------------------------------------------------------
// skf_tb_pkg
// Register map of the scalar Kalman filter, shared by stimulus and checker.
// ----------------------------------------------------------------------------
package skf_tb_pkg;

    localparam logic [2:0] REG_PROCESS_NOISE = 3'h0;
    localparam logic [2:0] REG_MEASURE_NOISE = 3'h4;

endpackage

>>> tb/skf_checker.sv
// ----------------------------------------------------------------------------
// skf_checker
// Watches the sample, estimate and register channels of the Kalman filter,
// keeps its own copy of the filter state and noise settings, predicts each
// estimate when a sample word is taken, and compares every estimate word
// against that prediction and each read of Q or R against its copy.
// ----------------------------------------------------------------------------
module skf_checker
    import skf_pkg::*;
    import skf_tb_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [SKF_SAMPLE_WIDTH-1:0] i_measurement,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [31:0]                 i_estimate,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [2:0]                  i_paddr,
    input  logic [31:0]                 i_pwdata,
    input  logic [31:0]                 i_prdata,
    input  logic                        i_pready,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] q_noise;
    logic [31:0] r_noise;
    logic [31:0] est_q16;
    logic [31:0] cov_q16;
    logic [31:0] estimate_fifo[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_results = 0;
    end

    // one filter update; returns the new estimate
    function automatic logic [31:0] kalman_update(input logic signed [SKF_SAMPLE_WIDTH-1:0] meas);
        logic [32:0]       prior;
        logic [32:0]       denom;
        logic [63:0]       gain;
        longint            sample_fx;
        longint            diff;
        longint            next_est;
        longint unsigned   mag;
        longint unsigned   corr;
        prior = {1'b0, cov_q16} + {1'b0, q_noise};
        if (prior[32]) begin
            prior = {1'b0, 32'hFFFF_FFFF};
        end
        denom = prior + {1'b0, r_noise};
        gain  = (denom == '0) ? 64'd0
                              : ({31'd0, prior} << SKF_FRAC_BITS) / {31'd0, denom};
        sample_fx = longint'(meas) * (longint'(1) << SKF_FRAC_BITS);
        diff      = sample_fx - longint'({32'd0, est_q16});
        mag       = (diff < 0) ? longint'(-diff) : diff;
        corr      = (mag * gain) >> SKF_FRAC_BITS;
        next_est  = (diff < 0) ? longint'({32'd0, est_q16}) - longint'(corr)
                               : longint'({32'd0, est_q16}) + longint'(corr);
        if (next_est <= 0) begin
            est_q16 = '0;
        end else if (next_est > 64'sh0000_0000_FFFF_FFFF) begin
            est_q16 = 32'hFFFF_FFFF;
        end else begin
            est_q16 = next_est[31:0];
        end
        cov_q16 = 32'((((64'd1 << SKF_FRAC_BITS) - gain) * {31'd0, prior}) >> SKF_FRAC_BITS);
        return est_q16;
    endfunction

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            q_noise = Q_RESET;
            r_noise = R_RESET;
            est_q16 = '0;
            cov_q16 = '0;
            estimate_fifo.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (i_paddr)
                        REG_PROCESS_NOISE: q_noise = i_pwdata;
                        REG_MEASURE_NOISE: r_noise = i_pwdata;
                        default: ;
                    endcase
                end else begin
                    case (i_paddr)
                        REG_PROCESS_NOISE: want = q_noise;
                        REG_MEASURE_NOISE: want = r_noise;
                        default:           want = i_prdata;
                    endcase
                    if (i_prdata !== want) begin
                        $display("%t register read at %h: expected %h, actual %h",
                                 $realtime, i_paddr, want, i_prdata);
                        o_errors++;
                    end
                end
            end
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (estimate_fifo.size() == 0) begin
                    $display("%t unexpected estimate word: expected none, actual %h",
                             $realtime, i_estimate);
                    o_errors++;
                end else begin
                    want = estimate_fifo.pop_front();
                    if (i_estimate !== want) begin
                        $display("%t estimate mismatch: expected %h, actual %h",
                                 $realtime, want, i_estimate);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                estimate_fifo.push_back(kalman_update($signed(i_measurement)));
            end
        end
        o_pending = estimate_fifo.size();
    end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the scalar Kalman filter: directed samples and noise settings
// for the edge cases (full gain, zero gain, covariance saturation, negative
// clamp), then random phases of tracked and full-range samples under several
// idle and stall mixes, with a long receiver hold-off and a sender pause.
// ----------------------------------------------------------------------------
module tb;
    import skf_pkg::*;
    import skf_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 85;
    localparam int LATENCY_CYCLES = 60;

    localparam int SEND_IDLE_PCT[4]  = '{0, 87, 0, 38};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 87, 38};

    localparam logic [15:0] EDGE_SAMPLES[7] =
        '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA};

    logic                        i_clk;
    logic                        i_rst_n       = 1'b0;
    logic                        i_valid       = 1'b0;
    logic                        o_stall;
    logic [SKF_SAMPLE_WIDTH-1:0] i_measurement = '0;
    logic                        o_valid;
    logic                        i_stall       = 1'b0;
    logic [31:0]                 o_estimate;
    logic                        psel          = 1'b0;
    logic                        penable       = 1'b0;
    logic                        pwrite        = 1'b0;
    logic [2:0]                  paddr         = '0;
    logic [31:0]                 pwdata        = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    int errors;
    int pending;
    int results;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int n_sent         = 0;
    int n_settings     = 0;
    int level          = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    scalar_kalman_filter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_measurement (i_measurement),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_estimate    (o_estimate),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    skf_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_measurement (i_measurement),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_estimate    (o_estimate),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_results     (results)
    );

    // receiver: random stall, or a counted hold-off when requested
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_stall = 1'b1;
                hold_cycles--;
            end else begin
                i_stall = ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    task automatic send_word(input logic [SKF_SAMPLE_WIDTH-1:0] sample);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_measurement = sample;
        do @(posedge i_clk); while (o_stall);
        n_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        wait (pending == 0);
    endtask

    task automatic apb_access(input logic is_write, input logic [2:0] addr,
                              input logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = is_write;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_noise(input logic [31:0] q, input logic [31:0] r);
        drain_results();
        apb_access(1'b1, REG_PROCESS_NOISE, q);
        apb_access(1'b1, REG_MEASURE_NOISE, r);
        apb_access(1'b0, REG_PROCESS_NOISE, '0);
        apb_access(1'b0, REG_MEASURE_NOISE, '0);
        n_settings++;
    endtask

    initial begin
        logic [31:0] q;
        logic [31:0] r;
        int          sample;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // default noise settings, field extremes
        foreach (EDGE_SAMPLES[k]) send_word(EDGE_SAMPLES[k]);
        // full gain: estimate follows the sample, negative clamps to zero
        set_noise(32'hFFFF_FFFF, 32'h0);
        send_word(-16'sd20);
        send_word(16'sd5);
        // zero covariance and zero noise: zero gain
        set_noise(32'h0, 32'h0);
        send_word(16'sd100);
        send_word(-16'sd100);
        send_word(16'h7FFF);
        // covariance add saturates
        set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (3) send_word(16'h7FFF);
        repeat (2) send_word(16'h8000);
        set_noise(32'h0, 32'hFFFF_FFFF);
        send_word(16'h7FFF);
        send_word(16'h8000);
        send_word(16'h1234);

        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(3))
                0: begin
                    q = $urandom();
                    r = $urandom();
                end
                1: begin
                    q = $urandom_range(32'h1_0000);
                    r = $urandom_range(32'h20_0000);
                end
                2: begin
                    q = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
                    r = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
                end
                default: begin
                    q = Q_RESET;
                    r = R_RESET;
                end
            endcase
            set_noise(q, r);
            send_idle_pct  = SEND_IDLE_PCT[ph % 4];
            recv_stall_pct = RECV_STALL_PCT[ph % 4];
            level          = int'($urandom_range(64000)) - 32000;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 0 && n == 30) begin
                    hold_cycles = 400;
                end
                if (ph == 4 && n == 40) begin
                    drain_results();
                end
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: begin
                        // slowly drifting level with sensor noise
                        level  = level + int'($urandom_range(200)) - 100;
                        level  = (level > 31000) ? 31000 : (level < -31000) ? -31000 : level;
                        sample = level + int'($urandom_range(2000)) - 1000;
                    end
                    6, 7, 8: sample = int'($urandom_range(16'hFFFF));
                    default: begin
                        case ($urandom_range(3))
                            0:       sample = 32767;
                            1:       sample = -32768;
                            2:       sample = 0;
                            default: sample = -1;
                        endcase
                    end
                endcase
                send_word(sample[SKF_SAMPLE_WIDTH-1:0]);
            end
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_results();
        repeat (LATENCY_CYCLES) @(posedge i_clk);

        $display("Covered %0d samples, %0d estimates, %0d noise settings incl. zero and full scale,",
                 n_sent, results, n_settings);
        $display("under idle/stall mixes with a long output hold-off and an input pause.");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Timeout with %0d estimates still outstanding", pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
rtl/skf_pkg.sv
rtl/skf_seq.sv
rtl/skf_dp.sv
rtl/scalar_kalman_filter.sv
tb/skf_tb_pkg.sv
tb/skf_checker.sv
tb/tb.sv
